[rtl/convex_hull_monotone_chain_assert.svh]
// Assertion macros for the convex hull block checker.
// Used by chmc_checker.sv; expects clk and arst_n in scope.
`ifndef CONVEX_HULL_MONOTONE_CHAIN_ASSERT_SVH
`define CONVEX_HULL_MONOTONE_CHAIN_ASSERT_SVH

// same-cycle implication
`define CHMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/chmc_pkg.sv]
// Shared types and constants for the convex hull block.
// No dependencies.
`default_nettype none
package chmc_pkg;
	localparam int MAX_POINTS_DEF = 64;
	localparam int RESULT_LIMIT   = 64;
	localparam int XW             = 32;
	localparam int IDW            = 6;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ADMIT,
		ST_INS_CMP,
		ST_HULL_INIT,
		ST_HULL_C,
		ST_HULL_CW,
		ST_HULL_CHK,
		ST_HULL_RA,
		ST_HULL_RO,
		ST_HULL_MUL,
		ST_HULL_CMP,
		ST_HULL_NEXT,
		ST_TRIM,
		ST_OUT_SEL,
		ST_OUT_RS,
		ST_OUT_RP,
		ST_OUT_EM,
		ST_OUT_EMPTY
	} state_t;

	typedef struct packed {
		logic load_in;
		logic set_ovf;
		logic ins_rd;
		logic ins_shift;
		logic ins_put;
		logic hull_init;
		logic rd_c;
		logic cap_c;
		logic rd_sa;
		logic rd_sb;
		logic cap_a;
		logic mul;
		logic pop;
		logic push;
		logic trim;
		logic out_init;
		logic out_rs;
		logic out_rp;
		logic emit;
		logic emit_empty;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic j_zero;
		logic last;
		logic ahead;
		logic can_pop;
		logic not_left;
		logic done;
		logic empty;
		logic out_last;
	} status_t;
endpackage
`default_nettype wire

[rtl/chmc_ctrl.sv]
// Controller state machine for the convex hull block.
// Depends on chmc_pkg; drives chmc_datapath through cmd_t.
`default_nettype none
module chmc_ctrl
	import chmc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire status_t sts,
	output cmd_t         cmd
);
	state_t state_q, state_nxt, fin_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign fin_st = sts.last ? ST_HULL_INIT : ST_IDLE;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_ADMIT;
			end
			ST_ADMIT: begin
				if (sts.full || sts.j_zero) state_nxt = fin_st;
				else state_nxt = ST_INS_CMP;
			end
			ST_INS_CMP: begin
				if (sts.ahead) state_nxt = ST_ADMIT;
				else state_nxt = fin_st;
			end
			ST_HULL_INIT: state_nxt = ST_HULL_C;
			ST_HULL_C:    state_nxt = ST_HULL_CW;
			ST_HULL_CW:   state_nxt = ST_HULL_CHK;
			ST_HULL_CHK: begin
				if (sts.can_pop) state_nxt = ST_HULL_RA;
				else state_nxt = ST_HULL_NEXT;
			end
			ST_HULL_RA:  state_nxt = ST_HULL_RO;
			ST_HULL_RO:  state_nxt = ST_HULL_MUL;
			ST_HULL_MUL: state_nxt = ST_HULL_CMP;
			ST_HULL_CMP: begin
				if (sts.not_left) state_nxt = ST_HULL_CHK;
				else state_nxt = ST_HULL_NEXT;
			end
			ST_HULL_NEXT: begin
				if (sts.done) state_nxt = ST_TRIM;
				else state_nxt = ST_HULL_C;
			end
			ST_TRIM: state_nxt = ST_OUT_SEL;
			ST_OUT_SEL: begin
				if (sts.empty) state_nxt = ST_OUT_EMPTY;
				else state_nxt = ST_OUT_RS;
			end
			ST_OUT_RS: state_nxt = ST_OUT_RP;
			ST_OUT_RP: state_nxt = ST_OUT_EM;
			ST_OUT_EM: begin
				if (sts.out_last) state_nxt = ST_IDLE;
				else state_nxt = ST_OUT_RS;
			end
			ST_OUT_EMPTY: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.load_in = start;
			end
			ST_ADMIT: begin
				if (sts.full) cmd.set_ovf = 1'b1;
				else if (sts.j_zero) cmd.ins_put = 1'b1;
				else cmd.ins_rd = 1'b1;
			end
			ST_INS_CMP: begin
				if (sts.ahead) cmd.ins_shift = 1'b1;
				else cmd.ins_put = 1'b1;
			end
			ST_HULL_INIT: cmd.hull_init = 1'b1;
			ST_HULL_C:    cmd.rd_c = 1'b1;
			ST_HULL_CW:   cmd.cap_c = 1'b1;
			ST_HULL_CHK: begin
				if (sts.can_pop) cmd.rd_sa = 1'b1;
				else cmd.push = 1'b1;
			end
			ST_HULL_RA:  cmd.rd_sb = 1'b1;
			ST_HULL_RO:  cmd.cap_a = 1'b1;
			ST_HULL_MUL: cmd.mul = 1'b1;
			ST_HULL_CMP: begin
				if (sts.not_left) cmd.pop = 1'b1;
				else cmd.push = 1'b1;
			end
			ST_HULL_NEXT: ;
			ST_TRIM:      cmd.trim = 1'b1;
			ST_OUT_SEL:   cmd.out_init = 1'b1;
			ST_OUT_RS:    cmd.out_rs = 1'b1;
			ST_OUT_RP:    cmd.out_rp = 1'b1;
			ST_OUT_EM: begin
				cmd.emit  = 1'b1;
				cmd.clear = sts.out_last;
			end
			ST_OUT_EMPTY: begin
				cmd.emit_empty = 1'b1;
				cmd.clear      = 1'b1;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[rtl/chmc_datapath.sv]
// Datapath: sorted point memory, hull stack memory, orientation test, output regs.
// Depends on chmc_pkg; commanded by chmc_ctrl.
`default_nettype none
module chmc_datapath
	import chmc_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output status_t                    sts,
	input  wire logic signed [XW-1:0]  point_x,
	input  wire logic signed [XW-1:0]  point_y,
	input  wire logic [IDW-1:0]        point_id,
	input  wire logic                  set_last,
	output logic                       strobe,
	output logic [IDW-1:0]             hull_id,
	output logic signed [XW-1:0]       hull_x,
	output logic signed [XW-1:0]       hull_y,
	output logic                       hull_empty,
	output logic                       overflow,
	output logic                       hull_last
);
	localparam int IW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW         = $clog2(MAX_POINTS + 1);
	localparam int STACK_SIZE = 2 * MAX_POINTS + 2;
	localparam int SAW        = $clog2(STACK_SIZE);
	localparam int SW         = $clog2(STACK_SIZE + 1);
	localparam int PW         = 2 * XW + IDW;
	localparam int MW         = 2 * XW + 2;

	// point memory, kept sorted by (x, y): {id, y, x}
	logic [PW-1:0]  pts_mem [MAX_POINTS];
	logic [PW-1:0]  pts_rd_q;
	logic [IW-1:0]  pts_raddr;
	logic           pts_we;
	logic [PW-1:0]  pts_wdata;

	logic [IW-1:0]  stk_mem [STACK_SIZE];
	logic [IW-1:0]  stk_rd_q;
	logic [SAW-1:0] stk_raddr;
	logic           stk_we;

	logic signed [XW-1:0] nx_q, ny_q, cx_q, cy_q, ax_q, ay_q;
	logic [IDW-1:0]       nid_q;
	logic                 nlast_q, ovf_q, upper_q, done_q;
	logic [CW-1:0]        cnt_q, j_q, ci_q;
	logic [SW-1:0]        dep_q, lower_q, k_q, dep_inc, dep_m1, dep_m2;
	logic signed [MW-1:0] p1_q, p2_q;

	logic signed [XW-1:0] rx, ry;
	logic signed [XW:0]   dax, day, dcx, dcy;

	assign rx = signed'(pts_rd_q[XW-1:0]);
	assign ry = signed'(pts_rd_q[2*XW-1:XW]);

	assign dep_m1  = dep_q - SW'(1);
	assign dep_m2  = dep_q - SW'(2);
	assign dep_inc = (dep_q < SW'(STACK_SIZE)) ? dep_q + SW'(1) : dep_q;

	// read address muxes
	always_comb begin
		pts_raddr = ci_q[IW-1:0];
		if (cmd.ins_rd) pts_raddr = IW'(j_q - CW'(1));
		else if (cmd.rd_sb || cmd.cap_a || cmd.out_rp) pts_raddr = stk_rd_q;
		stk_raddr = k_q[SAW-1:0];
		if (cmd.rd_sa) stk_raddr = dep_m1[SAW-1:0];
		else if (cmd.rd_sb) stk_raddr = dep_m2[SAW-1:0];
	end

	assign pts_we    = cmd.ins_shift || cmd.ins_put;
	assign pts_wdata = cmd.ins_shift ? pts_rd_q : {nid_q, ny_q, nx_q};
	assign stk_we    = cmd.push && (dep_q < SW'(STACK_SIZE));

	always_ff @(posedge clk) begin
		if (pts_we) pts_mem[j_q[IW-1:0]] <= pts_wdata;
		pts_rd_q <= pts_mem[pts_raddr];
		if (stk_we) stk_mem[dep_q[SAW-1:0]] <= ci_q[IW-1:0];
		stk_rd_q <= stk_mem[stk_raddr];
	end

	// orientation: (a - o) x (c - o); o is the point just read
	assign dax = (XW+1)'(ax_q) - (XW+1)'(rx);
	assign day = (XW+1)'(ay_q) - (XW+1)'(ry);
	assign dcx = (XW+1)'(cx_q) - (XW+1)'(rx);
	assign dcy = (XW+1)'(cy_q) - (XW+1)'(ry);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			nx_q    <= point_x;
			ny_q    <= point_y;
			nid_q   <= point_id;
			nlast_q <= set_last;
		end
		if (cmd.cap_c) begin
			cx_q <= rx;
			cy_q <= ry;
		end
		if (cmd.cap_a) begin
			ax_q <= rx;
			ay_q <= ry;
		end
		if (cmd.mul) begin
			p1_q <= dax * dcy;
			p2_q <= day * dcx;
		end
		if (cmd.emit) begin
			hull_id    <= pts_rd_q[PW-1:2*XW];
			hull_x     <= rx;
			hull_y     <= ry;
			hull_empty <= 1'b0;
			overflow   <= ovf_q;
			hull_last  <= sts.out_last;
		end else if (cmd.emit_empty) begin
			hull_id    <= '0;
			hull_x     <= '0;
			hull_y     <= '0;
			hull_empty <= 1'b1;
			overflow   <= ovf_q;
			hull_last  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			j_q     <= '0;
			ci_q    <= '0;
			ovf_q   <= 1'b0;
			upper_q <= 1'b0;
			done_q  <= 1'b0;
			dep_q   <= '0;
			lower_q <= '0;
			k_q     <= '0;
			strobe  <= 1'b0;
		end else begin
			strobe <= cmd.emit || cmd.emit_empty;
			if (cmd.load_in) j_q <= cnt_q;
			if (cmd.set_ovf) ovf_q <= 1'b1;
			if (cmd.ins_shift) j_q <= j_q - CW'(1);
			if (cmd.ins_put) cnt_q <= cnt_q + CW'(1);
			if (cmd.hull_init) begin
				dep_q   <= '0;
				ci_q    <= '0;
				upper_q <= 1'b0;
				done_q  <= 1'b0;
			end
			if (cmd.pop) dep_q <= dep_m1;
			if (cmd.push) begin
				dep_q <= dep_inc;
				if (!upper_q) begin
					if (ci_q == cnt_q - CW'(1)) begin
						upper_q <= 1'b1;
						lower_q <= dep_inc;
						if (cnt_q >= CW'(2)) ci_q <= cnt_q - CW'(2);
						else done_q <= 1'b1;
					end else begin
						ci_q <= ci_q + CW'(1);
					end
				end else if (ci_q == '0) begin
					done_q <= 1'b1;
				end else begin
					ci_q <= ci_q - CW'(1);
				end
			end
			// closing point repeats the first one
			if (cmd.trim && dep_q != '0) dep_q <= dep_m1;
			if (cmd.out_init) k_q <= '0;
			if (cmd.emit) k_q <= k_q + SW'(1);
			if (cmd.clear) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.full     = (cnt_q == CW'(MAX_POINTS));
		sts.j_zero   = (j_q == '0);
		sts.last     = nlast_q;
		sts.ahead    = (nx_q < rx) || ((nx_q == rx) && (ny_q < ry));
		sts.can_pop  = upper_q ? (dep_q > lower_q) : (dep_q >= SW'(2));
		sts.not_left = (p1_q <= p2_q);
		sts.done     = done_q;
		sts.empty    = (dep_q == '0);
		sts.out_last = ((k_q + SW'(1)) == dep_q) || ((32'(k_q) + 32'd1) == 32'(RESULT_LIMIT));
	end
endmodule
`default_nettype wire

[rtl/convex_hull_monotone_chain.sv]
// Top level of the convex hull block: controller plus datapath.
// Depends on chmc_pkg, chmc_ctrl, chmc_datapath.
`default_nettype none
// Convex hull (monotone chain). Points are offered one word at a time with
// start; a word is taken on a clock edge where start is high and busy is low.
// Each point is inserted into a sorted store as it arrives: every stored
// point that sorts after it is read, compared and shifted up one place,
// then the point is written into the gap. A point beyond MAX_POINTS is
// dropped and flagged. The word with set_last starts the hull walk over the
// sorted store: a setup step, then for each candidate point a read of the
// point and a stack depth check, and while the stack is deep enough an
// orientation test that pops on a non-left turn, each test reading the stack and point
// memories one word at a time and using one registered 33x33 multiply pair;
// a trim step then drops the closing point. Vertices leave counter-clockwise
// from the lowest-x point after a setup step, one word per vertex, at
// most RESULT_LIMIT of them. Each result word is on the hull ports for
// exactly one cycle with strobe high; the receiver cannot stall it, so it
// must take every strobed word. A one-point set returns a single word with
// hull_empty set. busy stays high from an accepted point until its
// insertion, or a whole hull output, is finished.
module convex_hull_monotone_chain
	import chmc_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic signed [XW-1:0] point_x,
	input  wire logic signed [XW-1:0] point_y,
	input  wire logic [IDW-1:0]       point_id,
	input  wire logic                 set_last,
	output logic                      strobe,
	output logic [IDW-1:0]            hull_id,
	output logic signed [XW-1:0]      hull_x,
	output logic signed [XW-1:0]      hull_y,
	output logic                      hull_empty,
	output logic                      overflow,
	output logic                      hull_last
);
	cmd_t    cmd;
	status_t sts;

	// sequencing: insertion sort, chain walk, output
	chmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// memories, orientation test and result registers
	chmc_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_id   (point_id),
		.set_last   (set_last),
		.strobe     (strobe),
		.hull_id    (hull_id),
		.hull_x     (hull_x),
		.hull_y     (hull_y),
		.hull_empty (hull_empty),
		.overflow   (overflow),
		.hull_last  (hull_last)
	);
endmodule
`default_nettype wire

[rtl/chmc_checker.sv]
// Port-level checker for the convex hull block, bound to the top level.
// Depends on chmc_pkg and convex_hull_monotone_chain_assert.svh.
`default_nettype none
`include "convex_hull_monotone_chain_assert.svh"
module chmc_props
	import chmc_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire logic signed [XW-1:0] point_x,
	input wire logic signed [XW-1:0] point_y,
	input wire logic [IDW-1:0]       point_id,
	input wire logic                 set_last,
	input wire logic                 strobe,
	input wire logic [IDW-1:0]       hull_id,
	input wire logic signed [XW-1:0] hull_x,
	input wire logic signed [XW-1:0] hull_y,
	input wire logic                 hull_empty,
	input wire logic                 overflow,
	input wire logic                 hull_last
);
	logic zero_fields;

	assign zero_fields = (hull_id == '0) && (hull_x == '0) && (hull_y == '0);

	`CHMC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`CHMC_ASSERT_NOW(a_empty_last, strobe && hull_empty, hull_last, "empty hull word not last")
	`CHMC_ASSERT_NOW(a_empty_zero, strobe && hull_empty, zero_fields, "empty hull word not zero")
	`CHMC_ASSERT_NOW(a_last_idle, strobe, busy == !hull_last, "busy disagrees with hull progress")
endmodule

bind convex_hull_monotone_chain chmc_props u_chk (.*);
`default_nettype wire
